[hdl/stepper_ramp_pulse_generator_core_macros.svh]
// ---------------------------------------------------------------------------
// stepper ramp pulse generator assertion macros
// shared concurrent assertion wrappers, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PULSE_GENERATOR_CORE_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define SRPG_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property for logic without a reset input
`define SRPG_ASSERT_NR(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRPG_ASSERT(name, clk, rst_n, prop, msg)
`define SRPG_ASSERT_NR(name, clk, prop, msg)
`endif

`endif

[hdl/srpg_pkg.sv]
// ---------------------------------------------------------------------------
// srpg_pkg
// shared constants, types and ramp table of the stepper ramp pulse generator
// ---------------------------------------------------------------------------
`default_nettype none

package srpg_pkg;

    localparam int STEP_W          = 16;
    localparam int RELOAD_W        = 16;
    localparam int CMD_W           = 2;
    localparam int ENTRY_W         = 11;
    localparam int RAMP_ROM_SIZE   = 259;
    localparam int ROM_AW          = $clog2(RAMP_ROM_SIZE);
    localparam int RAMP_LEN_DEF    = 259;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [RELOAD_W-1:0] RELOAD_INIT_RST = 16'd100;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic                move_finished;
        logic [RELOAD_W-1:0] reload_now;
        logic [STEP_W-1:0]   steps_done;
        logic                running;
        logic                pwm_level;
    } srpg_result_t;

    localparam int RESULT_W     = $bits(srpg_result_t);
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;
    localparam int IN_TDATA_W   = STEP_W;

    // acceleration / deceleration step table, duplicated pair kept as given
    localparam logic [ENTRY_W-1:0] RAMP_ROM [RAMP_ROM_SIZE] = '{
        11'd0, 11'd153, 11'd771, 11'd1104, 11'd1379, 11'd1589, 11'd1736, 11'd1824,
        11'd1862, 11'd1862, 11'd1830, 11'd1777, 11'd1710,
        11'd1635, 11'd1555, 11'd1473, 11'd1393, 11'd1314, 11'd1239, 11'd1168,
        11'd1101, 11'd1037, 11'd979, 11'd923, 11'd871,
        11'd824, 11'd780, 11'd738, 11'd699, 11'd664, 11'd630, 11'd599, 11'd570,
        11'd543, 11'd518, 11'd494, 11'd472, 11'd452, 11'd432,
        11'd413, 11'd397, 11'd380, 11'd365, 11'd351, 11'd337, 11'd324, 11'd313,
        11'd300, 11'd291, 11'd279, 11'd270, 11'd261, 11'd252,
        11'd244, 11'd236, 11'd228, 11'd221, 11'd214, 11'd207, 11'd201, 11'd195,
        11'd190, 11'd184, 11'd178, 11'd174, 11'd168, 11'd164,
        11'd160, 11'd155,
        11'd160, 11'd155, 11'd152, 11'd147, 11'd143, 11'd140, 11'd136, 11'd133,
        11'd129, 11'd127, 11'd123, 11'd120, 11'd118, 11'd114,
        11'd113, 11'd109, 11'd107, 11'd105, 11'd102, 11'd100, 11'd98, 11'd95,
        11'd94, 11'd92, 11'd89, 11'd88, 11'd86, 11'd84, 11'd83,
        11'd81, 11'd79, 11'd77, 11'd77, 11'd74, 11'd73, 11'd72, 11'd70, 11'd69,
        11'd68, 11'd66, 11'd65, 11'd64, 11'd63, 11'd62, 11'd60, 11'd60,
        11'd58, 11'd57, 11'd56, 11'd56, 11'd54, 11'd53, 11'd52, 11'd52, 11'd50,
        11'd50, 11'd49, 11'd48, 11'd47, 11'd46, 11'd46, 11'd45, 11'd44,
        11'd43, 11'd43, 11'd41, 11'd42, 11'd40, 11'd40, 11'd39, 11'd39, 11'd37,
        11'd38, 11'd36, 11'd36, 11'd36, 11'd35, 11'd34, 11'd34, 11'd33,
        11'd33, 11'd32, 11'd31, 11'd32, 11'd30, 11'd30, 11'd30, 11'd29, 11'd29,
        11'd28, 11'd28, 11'd27, 11'd27, 11'd26, 11'd26, 11'd26, 11'd25,
        11'd25, 11'd24, 11'd24, 11'd23, 11'd23, 11'd23, 11'd23, 11'd22, 11'd21,
        11'd21, 11'd21, 11'd21, 11'd20, 11'd20, 11'd19, 11'd20, 11'd18,
        11'd19, 11'd18, 11'd18, 11'd18, 11'd17, 11'd17, 11'd16, 11'd17, 11'd16,
        11'd15, 11'd16, 11'd15, 11'd15, 11'd14, 11'd14, 11'd14, 11'd14,
        11'd14, 11'd13, 11'd13, 11'd12, 11'd12, 11'd13, 11'd11, 11'd12, 11'd11,
        11'd11, 11'd11, 11'd11, 11'd10, 11'd10, 11'd10, 11'd9, 11'd10,
        11'd9, 11'd8, 11'd9, 11'd8, 11'd8, 11'd8, 11'd8, 11'd7, 11'd8, 11'd6,
        11'd7, 11'd7, 11'd6, 11'd6, 11'd6, 11'd5, 11'd6, 11'd5, 11'd5, 11'd5,
        11'd4,
        11'd5, 11'd4, 11'd3, 11'd4, 11'd4, 11'd3, 11'd3, 11'd3, 11'd2, 11'd2,
        11'd3, 11'd2, 11'd1, 11'd2, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 11'd0,
        11'd1
    };

endpackage

`default_nettype wire

[hdl/stepper_ramp_pulse_generator_core.sv]
// ---------------------------------------------------------------------------
// stepper_ramp_pulse_generator_core
// table-driven trapezoidal step pulse generator for one motor channel
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one command word per cycle when ready: tuser holds the
//   command (tick, start, stop) and tdata the step count, read only with start.
//   m_axis returns exactly one status word per command word: pulse level,
//   run flag, steps done, current reload and a move-finished flag.
//   cfg_we / cfg_wdata write reload_init; write it only while no command
//   word is in flight.
// throughput and table read:
//   one command word per cycle while m_axis drains the status words; each
//   status word is registered in the output buffer, or parked in the skid
//   entry under a stall. the ramp table is read with the next step counts
//   and registered, so overflows on back-to-back ticks need no stall.
// reset:
//   counter and counts clear, reload and reload_init return to 100, the
//   move is stopped and the table needs no clearing pass.
// stalls:
//   a two-word output buffer absorbs one stalled word; s_axis_tready only
//   drops once both words wait on m_axis_tready.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stepper_ramp_pulse_generator_core_macros.svh"

module stepper_ramp_pulse_generator_core #(
    parameter int RAMP_LEN    = srpg_pkg::RAMP_LEN_DEF,
    parameter int COUNT_WIDTH = srpg_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write, reload_init
    input  wire logic                             cfg_we,
    input  wire logic [srpg_pkg::RELOAD_W-1:0]    cfg_wdata,
    // command stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [srpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] step_count
    input  wire logic [srpg_pkg::CMD_W-1:0]       s_axis_tuser,  // [1:0] cmd
    // status stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] pwm_level, [1] running, [17:2] steps_done, [33:18] reload_now,
    // [34] move_finished, upper bits zero
    output logic      [srpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import srpg_pkg::*;

    // move state
    logic [RELOAD_W-1:0]    reload_init_reg;
    logic [COUNT_WIDTH-1:0] count_value_reg;
    logic [COUNT_WIDTH-1:0] count_value_next;
    logic [COUNT_WIDTH-1:0] reload_value_reg;
    logic [COUNT_WIDTH-1:0] reload_value_next;
    logic [STEP_W-1:0]      steps_passed_reg;
    logic [STEP_W-1:0]      steps_passed_next;
    logic [STEP_W-1:0]      steps_total_reg;
    logic [STEP_W-1:0]      steps_total_next;
    logic                   run_flag_reg;
    logic                   run_flag_next;
    logic                   pulse_level_reg;
    logic                   pulse_level_next;

    logic                   in_acc;
    logic                   finish_now;
    logic [COUNT_WIDTH-1:0] init_cw;
    logic [COUNT_WIDTH-1:0] reload_ramped;
    logic [STEP_W-1:0]      passed_inc;
    logic [ENTRY_W-1:0]     acc_entry;
    logic [ENTRY_W-1:0]     dec_entry;
    logic [STEP_W-1:0]      dec_idx_next;
    logic [31:0]            reload_ext;
    srpg_result_t           result;
    srpg_result_t           out_word;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign init_cw = COUNT_WIDTH'(reload_init_reg);

    // ramped reload: accel entry of steps done, minus decel entry of
    // steps remaining, both prefetched for the present counts
    assign reload_ramped = reload_value_reg + COUNT_WIDTH'(acc_entry)
                           - COUNT_WIDTH'(dec_entry);
    assign passed_inc    = steps_passed_reg + STEP_W'(1);

    always_comb
    begin
        count_value_next  = count_value_reg;
        reload_value_next = reload_value_reg;
        steps_passed_next = steps_passed_reg;
        steps_total_next  = steps_total_reg;
        run_flag_next     = run_flag_reg;
        pulse_level_next  = pulse_level_reg;
        finish_now        = 1'b0;
        if (in_acc)
        begin
            case (s_axis_tuser)
                CMD_START:
                begin
                    count_value_next  = init_cw;
                    reload_value_next = init_cw;
                    steps_total_next  = s_axis_tdata;
                    run_flag_next     = 1'b1;
                end
                CMD_STOP:
                begin
                    run_flag_next = 1'b0;
                end
                CMD_TICK:
                begin
                    if (run_flag_reg)
                    begin
                        if (&count_value_reg)
                        begin
                            pulse_level_next = !pulse_level_reg;
                            if (passed_inc >= steps_total_reg)
                            begin
                                // move complete
                                finish_now        = 1'b1;
                                run_flag_next     = 1'b0;
                                reload_value_next = init_cw;
                                count_value_next  = init_cw;
                                steps_total_next  = '0;
                                steps_passed_next = '0;
                            end
                            else
                            begin
                                count_value_next  = reload_value_reg;
                                reload_value_next = reload_ramped;
                                steps_passed_next = passed_inc;
                            end
                        end
                        else
                        begin
                            count_value_next = count_value_reg + COUNT_WIDTH'(1);
                        end
                    end
                end
                default:
                begin
                    // unused command leaves the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_init_reg  <= RELOAD_INIT_RST;
            count_value_reg  <= '0;
            reload_value_reg <= COUNT_WIDTH'(RELOAD_INIT_RST);
            steps_passed_reg <= '0;
            steps_total_reg  <= '0;
            run_flag_reg     <= 1'b0;
            pulse_level_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                reload_init_reg <= cfg_wdata;
            end
            count_value_reg  <= count_value_next;
            reload_value_reg <= reload_value_next;
            steps_passed_reg <= steps_passed_next;
            steps_total_reg  <= steps_total_next;
            run_flag_reg     <= run_flag_next;
            pulse_level_reg  <= pulse_level_next;
        end
    end

    // table lookup for the counts the next word will see
    assign dec_idx_next = steps_total_next - steps_passed_next;

    srpg_ramp_rom #(
        .RAMP_LEN (RAMP_LEN)
    ) u_ramp_rom (
        .clk       (clk),
        .acc_idx   (steps_passed_next),
        .dec_idx   (dec_idx_next),
        .acc_entry (acc_entry),
        .dec_entry (dec_entry)
    );

    // status word, taken after the command is applied
    assign reload_ext = 32'(reload_value_next);

    always_comb
    begin
        result.pwm_level     = pulse_level_next;
        result.running       = run_flag_next;
        result.steps_done    = steps_passed_next;
        result.reload_now    = reload_ext[RELOAD_W-1:0];
        result.move_finished = finish_now;
    end

    srpg_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_word)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_word);

    `SRPG_ASSERT(a_finish_clears, clk, rst_n, in_acc && finish_now |=> !run_flag_reg && (steps_passed_reg == '0) && (steps_total_reg == '0), "finished move left state behind")
    `SRPG_ASSERT(a_idle_tick_holds, clk, rst_n, in_acc && (s_axis_tuser == CMD_TICK) && !run_flag_reg |=> $stable(count_value_reg) && $stable(steps_passed_reg), "stopped tick changed the counter")

endmodule

`default_nettype wire

[hdl/srpg_ramp_rom.sv]
// ---------------------------------------------------------------------------
// srpg_ramp_rom
// dual read port ramp table, registered read, zero outside the ramp
// ---------------------------------------------------------------------------
`default_nettype none
`include "stepper_ramp_pulse_generator_core_macros.svh"

module srpg_ramp_rom #(
    parameter int RAMP_LEN = srpg_pkg::RAMP_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic [srpg_pkg::STEP_W-1:0]  acc_idx,
    input  wire logic [srpg_pkg::STEP_W-1:0]  dec_idx,
    output logic      [srpg_pkg::ENTRY_W-1:0] acc_entry,
    output logic      [srpg_pkg::ENTRY_W-1:0] dec_entry
);
    import srpg_pkg::*;

    // entries at or above the limit read as zero
    localparam int LIMIT = (RAMP_LEN < RAMP_ROM_SIZE) ? RAMP_LEN : RAMP_ROM_SIZE;
    localparam logic [STEP_W-1:0] LIMIT_W = STEP_W'(LIMIT);

    logic acc_hit;
    logic dec_hit;

    assign acc_hit = (acc_idx < LIMIT_W);
    assign dec_hit = (dec_idx < LIMIT_W);

    always_ff @(posedge clk)
    begin
        acc_entry <= acc_hit ? RAMP_ROM[acc_idx[ROM_AW-1:0]] : '0;
        dec_entry <= dec_hit ? RAMP_ROM[dec_idx[ROM_AW-1:0]] : '0;
    end

    `SRPG_ASSERT_NR(a_acc_beyond_zero, clk, !acc_hit |=> (acc_entry == '0), "acc entry beyond ramp not zero")
    `SRPG_ASSERT_NR(a_dec_beyond_zero, clk, !dec_hit |=> (dec_entry == '0), "dec entry beyond ramp not zero")

endmodule

`default_nettype wire

[hdl/srpg_skid.sv]
// ---------------------------------------------------------------------------
// srpg_skid
// two-entry result buffer, ready toward the core comes from a register
// ---------------------------------------------------------------------------
`default_nettype none
`include "stepper_ramp_pulse_generator_core_macros.svh"

module srpg_skid (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire srpg_pkg::srpg_result_t in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output srpg_pkg::srpg_result_t      out_data
);
    import srpg_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    srpg_result_t out_data_reg;
    srpg_result_t skid_data_reg;
    logic         push;
    logic         slot_free;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                if (push)
                begin
                    skid_data_reg <= in_data;
                end
            end
            else if (push)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= in_data;
        end
    end

    `SRPG_ASSERT(a_skid_implies_out, clk, rst_n, skid_valid_reg |-> out_valid_reg, "skid word without output word")
    `SRPG_ASSERT(a_stall_fills_skid, clk, rst_n, push && out_valid_reg && !out_ready |=> skid_valid_reg, "stalled word not parked")

endmodule

`default_nettype wire
